// ===== sv/gcr54_pkg.sv =====
// Package: shared types, constants and lookup tables of the GCR 5-to-4 decoder.
`default_nettype none

package gcr54_pkg;

    // Field widths
    localparam int GCR_W     = 8;
    localparam int DATA_W    = 8;
    localparam int TALLY_W   = 16;
    localparam int COUNT_W   = 4;
    localparam int SEL_W     = 2;
    localparam int CODE_W    = 5;
    localparam int NIB_W     = 4;
    localparam int ACC_W     = GCR_W + GCR_W;
    localparam int SUM_W     = COUNT_W + 1;

    // Register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_TABLE_SELECT = 1'b0;

    // Code handling constants
    localparam logic [SUM_W-1:0]   PAIR_BITS = SUM_W'(10);
    localparam logic [SUM_W-1:0]   HALF_ADD  = SUM_W'(GCR_W);
    localparam logic [DATA_W-1:0]  BAD_BYTE  = 8'h00;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;
    // bit n set when 5-bit code n is a legal GCR code (same for every table)
    localparam logic [31:0]        VALID_CODES = 32'h6EEC_EE00;

    typedef logic [NIB_W-1:0] nib_row_t [32];

    // Nibble tables: standard, then the three scrambled variants
    localparam nib_row_t NIBBLE_TABLE [4] = '{
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
          4'd0, 4'd8, 4'd0, 4'd1, 4'd0, 4'd12, 4'd4, 4'd5,
          4'd0, 4'd0, 4'd2, 4'd3, 4'd0, 4'd15, 4'd6, 4'd7,
          4'd0, 4'd9, 4'd10, 4'd11, 4'd0, 4'd13, 4'd14, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
          4'd0, 4'd9, 4'd1, 4'd0, 4'd0, 4'd13, 4'd5, 4'd4,
          4'd0, 4'd0, 4'd3, 4'd2, 4'd0, 4'd14, 4'd7, 4'd6,
          4'd0, 4'd8, 4'd11, 4'd10, 4'd0, 4'd12, 4'd15, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
          4'd0, 4'd10, 4'd2, 4'd1, 4'd0, 4'd14, 4'd6, 4'd5,
          4'd0, 4'd0, 4'd0, 4'd3, 4'd0, 4'd12, 4'd4, 4'd7,
          4'd0, 4'd9, 4'd8, 4'd11, 4'd0, 4'd13, 4'd15, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
          4'd0, 4'd11, 4'd3, 4'd0, 4'd0, 4'd15, 4'd7, 4'd4,
          4'd0, 4'd0, 4'd1, 4'd2, 4'd0, 4'd13, 4'd5, 4'd6,
          4'd0, 4'd8, 4'd9, 4'd10, 4'd0, 4'd12, 4'd14, 4'd0}
    };

    // Result of decoding one input byte against the held bits
    typedef struct packed {
        logic               pair;
        logic [DATA_W-1:0]  data;
        logic               err;
        logic [GCR_W-1:0]   next_bits;
        logic [COUNT_W-1:0] next_count;
    } unpack_t;

    function automatic logic code_ok(input logic [CODE_W-1:0] code);
        code_ok = VALID_CODES[code];
    endfunction

endpackage

`default_nettype wire

// ===== sv/gcr_5to4_table_decoder.sv =====
// Top level of the GCR 5-to-4 decoder: input register, decode, result register, APB register.
`default_nettype none

// Takes one raw GCR byte per transfer and returns exactly one result per byte.
// Throughput is one byte per clock while the output is not stalled; the path is the input
// register, then the result register, with the bit accumulator, the two 32-entry table lookups
// and the error count all updated in the single decode pass between them.
// A full result register that is stalled holds the input register, so the
// input stalls only when both stages are occupied. table_select (APB offset 0)
// picks the standard table or one of three scrambled ones and should only be
// written while no byte is in flight. A byte marked last_byte drops any held
// bits and clears the error count after its result.

module gcr_5to4_table_decoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [gcr54_pkg::GCR_W-1:0]       gcr_byte,
    input  wire logic                              last_byte,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   byte_valid,
    output logic [gcr54_pkg::DATA_W-1:0]           data_byte,
    output logic                                   code_error,
    output logic [gcr54_pkg::TALLY_W-1:0]          error_total,
    output logic                                   frame_end,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gcr54_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [gcr54_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gcr54_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                   pready
);
    import gcr54_pkg::*;

    logic [SEL_W-1:0]   table_select_reg;
    logic               s1_valid_reg;
    logic [GCR_W-1:0]   s1_byte_reg;
    logic               s1_last_reg;
    logic [GCR_W-1:0]   leftover_bits_reg;
    logic [COUNT_W-1:0] leftover_count_reg;
    logic [TALLY_W-1:0] error_tally_reg;
    logic [TALLY_W-1:0] error_tally_next;
    logic               out_valid_reg;
    logic               byte_valid_reg;
    logic [DATA_W-1:0]  data_byte_reg;
    logic               code_error_reg;
    logic [TALLY_W-1:0] error_total_reg;
    logic               frame_end_reg;
    logic               advance;
    logic               in_take;
    logic               cfg_write;
    unpack_t            dec;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_IDX_TABLE_SELECT)
                     ? {{(APB_DATA_W-SEL_W){1'b0}}, table_select_reg}
                     : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_select_reg <= '0;
        end
        else if (cfg_write && (paddr[APB_ADDR_W-1] == REG_IDX_TABLE_SELECT))
        begin
            table_select_reg <= pwdata[SEL_W-1:0];
        end
    end

    // Handshake: stage 1 moves on when the result register is free or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= gcr_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Decode pass
    gcr54_unpack u_unpack (
        .gcr_byte     (s1_byte_reg),
        .held_bits    (leftover_bits_reg),
        .held_count   (leftover_count_reg),
        .table_select (table_select_reg),
        .result       (dec)
    );

    // Saturating error count including this byte
    always_comb
    begin
        error_tally_next = error_tally_reg;
        if (dec.err && (error_tally_reg != TALLY_MAX))
        begin
            error_tally_next = error_tally_reg + TALLY_W'(1);
        end
    end

    // Accumulator and count state; last byte of a frame clears them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= '0;
            leftover_count_reg <= '0;
            error_tally_reg    <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            if (s1_last_reg)
            begin
                leftover_bits_reg  <= '0;
                leftover_count_reg <= '0;
                error_tally_reg    <= '0;
            end
            else
            begin
                leftover_bits_reg  <= dec.next_bits;
                leftover_count_reg <= dec.next_count;
                error_tally_reg    <= error_tally_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            byte_valid_reg  <= dec.pair;
            data_byte_reg   <= dec.data;
            code_error_reg  <= dec.err;
            error_total_reg <= error_tally_next;
            frame_end_reg   <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_valid  = byte_valid_reg;
    assign data_byte   = data_byte_reg;
    assign code_error  = code_error_reg;
    assign error_total = error_total_reg;
    assign frame_end   = frame_end_reg;

    // Checks
    a_err_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && code_error_reg |-> byte_valid_reg)
        else $error("code error flagged on a result without a byte");

    a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && code_error_reg |-> data_byte_reg == BAD_BYTE)
        else $error("bad code produced nonzero data");

    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        leftover_count_reg[0] == 1'b0 && leftover_count_reg <= COUNT_W'(GCR_W))
        else $error("held bit count out of reachable set");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && s1_last_reg
        |=> leftover_count_reg == '0 && error_tally_reg == '0)
        else $error("frame end did not clear accumulator and count");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

// ===== sv/gcr54_unpack.sv =====
// Single-pass unpack: accumulate one byte, split ten bits into two codes, look up nibbles.
`default_nettype none

module gcr54_unpack (
    input  wire logic [gcr54_pkg::GCR_W-1:0]   gcr_byte,
    input  wire logic [gcr54_pkg::GCR_W-1:0]   held_bits,
    input  wire logic [gcr54_pkg::COUNT_W-1:0] held_count,
    input  wire logic [gcr54_pkg::SEL_W-1:0]   table_select,
    output gcr54_pkg::unpack_t                 result
);
    import gcr54_pkg::*;

    logic [GCR_W-1:0]  held_masked;
    logic [ACC_W-1:0]  acc;
    logic [SUM_W-1:0]  bit_sum;
    logic [SUM_W-1:0]  shift_amt;
    logic [SUM_W-1:0]  keep_count;
    logic [ACC_W-1:0]  aligned;
    logic [CODE_W-1:0] code_hi;
    logic [CODE_W-1:0] code_lo;
    logic              both_ok;

    // Only the meaningful held bits enter the accumulator
    always_comb
    begin
        for (int i = 0; i < GCR_W; i++)
        begin
            held_masked[i] = held_bits[i] & (COUNT_W'(i) < held_count);
        end
    end

    assign acc       = {held_masked, gcr_byte};
    assign bit_sum   = {1'b0, held_count} + HALF_ADD;
    assign shift_amt = bit_sum - PAIR_BITS;
    assign aligned   = acc >> shift_amt;
    assign code_hi   = aligned[2*CODE_W-1:CODE_W];
    assign code_lo   = aligned[CODE_W-1:0];
    assign both_ok   = code_ok(code_hi) && code_ok(code_lo);

    // Bit count left over after this byte
    always_comb
    begin
        if (bit_sum >= PAIR_BITS)
        begin
            keep_count = shift_amt;
        end
        else
        begin
            keep_count = bit_sum;
        end
    end

    // Decode result and the bits to carry into the next byte
    always_comb
    begin
        result.pair = (bit_sum >= PAIR_BITS);
        result.err  = result.pair && !both_ok;
        if (result.pair && both_ok)
        begin
            result.data = {NIBBLE_TABLE[table_select][code_hi],
                           NIBBLE_TABLE[table_select][code_lo]};
        end
        else
        begin
            result.data = BAD_BYTE;
        end
        for (int i = 0; i < GCR_W; i++)
        begin
            result.next_bits[i] = acc[i] & (SUM_W'(i) < keep_count);
        end
        result.next_count = keep_count[COUNT_W-1:0];
    end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the GCR 5-to-4 decoder: queued driver, scoreboard monitor, APB table select.
`default_nettype none

module tb;

    import gcr54_pkg::*;

    // Decode table choices, written to the table_select register
    typedef enum logic [SEL_W-1:0] {
        TSEL_STANDARD,
        TSEL_SCRAMBLE_ONE,
        TSEL_SCRAMBLE_TWO,
        TSEL_SCRAMBLE_THREE
    } table_sel_t;

    // One input transfer
    typedef struct packed {
        logic [GCR_W-1:0] raw;
        logic             last;
    } gcr_item_t;

    // One output transfer
    typedef struct packed {
        logic               byte_valid;
        logic [DATA_W-1:0]  data_byte;
        logic               code_error;
        logic [TALLY_W-1:0] error_total;
        logic               frame_end;
    } gcr_result_t;

    localparam logic [4:0]         PAIR_LEN       = 5'd10;
    localparam logic [DATA_W-1:0]  BAD_DATA       = 8'h00;
    localparam logic [TALLY_W-1:0] TALLY_CEIL     = 16'hFFFF;
    localparam logic [31:0]        GOOD_CODE_MASK = 32'h6EEC_EE00;
    localparam int                 CYCLE_LIMIT    = 1000000;
    localparam int                 STALL_BURST    = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [GCR_W-1:0]      gcr_byte;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic                  byte_valid;
    logic [DATA_W-1:0]     data_byte;
    logic                  code_error;
    logic [TALLY_W-1:0]    error_total;
    logic                  frame_end;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Stimulus and scoreboard
    gcr_item_t   pending_items[$];
    gcr_result_t expected_results[$];
    gcr_item_t   next_item;
    gcr_result_t seen_result;
    int          good_codes[$];
    int          items_queued = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Flow control knobs, set by the sequence
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          sender_hold = 1'b0;
    bit          burst_arm = 1'b0;
    bit          burst_taken;
    int          burst_left;

    // Decoder shadow state
    table_sel_t         table_sel_q = TSEL_STANDARD;
    logic [GCR_W-1:0]   held_bits = '0;
    logic [COUNT_W-1:0] held_count = '0;
    logic [TALLY_W-1:0] err_tally = '0;

    gcr_5to4_table_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .gcr_byte    (gcr_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_valid  (byte_valid),
        .data_byte   (data_byte),
        .code_error  (code_error),
        .error_total (error_total),
        .frame_end   (frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Nibble lookup; entry n sits at bits [4n+3:4n]
    function automatic logic [NIB_W-1:0] nibble_of(input table_sel_t sel,
                                                   input logic [CODE_W-1:0] code);
        logic [127:0] row;
        case (sel)
            TSEL_STANDARD:       row = 128'h0ED0_BA90_76F0_3200_54C0_1080_0000_0000;
            TSEL_SCRAMBLE_ONE:   row = 128'h0FC0_AB80_67E0_2300_45D0_0190_0000_0000;
            TSEL_SCRAMBLE_TWO:   row = 128'h0FD0_B890_74C0_3000_56E0_12A0_0000_0000;
            default:             row = 128'h0EC0_A980_65D0_2100_47F0_03B0_0000_0000;
        endcase
        return row[code*4 +: 4];
    endfunction

    // Expected result of one input byte; advances the shadow state
    function automatic gcr_result_t decode_step(input logic [GCR_W-1:0] raw, input logic last);
        gcr_result_t        r;
        logic [15:0]        acc;
        logic [4:0]         cnt;
        logic [4:0]         sh;
        logic [CODE_W-1:0]  c_hi;
        logic [CODE_W-1:0]  c_lo;
        r   = '0;
        acc = {held_bits, raw};
        cnt = 5'(held_count) + 5'd8;
        if (cnt >= PAIR_LEN)
        begin
            sh   = cnt - PAIR_LEN;
            c_hi = CODE_W'(acc >> (sh + 5'd5));
            c_lo = CODE_W'(acc >> sh);
            r.byte_valid = 1'b1;
            if (GOOD_CODE_MASK[c_hi] && GOOD_CODE_MASK[c_lo])
                r.data_byte = {nibble_of(table_sel_q, c_hi), nibble_of(table_sel_q, c_lo)};
            else
            begin
                r.data_byte  = BAD_DATA;
                r.code_error = 1'b1;
                if (err_tally != TALLY_CEIL)
                    err_tally = err_tally + 1'b1;
            end
            cnt = sh;
        end
        held_bits     = GCR_W'(acc & ((16'h1 << cnt) - 16'h1));
        held_count    = cnt[COUNT_W-1:0];
        r.error_total = err_tally;
        r.frame_end   = last;
        // frame end drops held bits and the count after the result
        if (last)
        begin
            held_bits  = '0;
            held_count = '0;
            err_tally  = '0;
        end
        return r;
    endfunction

    // Driver: records accepted transfers, then offers the next queued item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            gcr_byte  <= '0;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(decode_step(gcr_byte, last_byte));
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && !sender_hold &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    in_valid  <= 1'b1;
                    gcr_byte  <= next_item.raw;
                    last_byte <= next_item.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatch_count++;
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        end
    endtask

    // Monitor: scoreboard compare and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            burst_left  <= 0;
            burst_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $error("output transfer with no expected result");
                end
                else
                begin
                    seen_result = expected_results.pop_front();
                    check_field("byte_valid", 16'(seen_result.byte_valid), 16'(byte_valid));
                    check_field("data_byte", 16'(seen_result.data_byte), 16'(data_byte));
                    check_field("code_error", 16'(seen_result.code_error), 16'(code_error));
                    check_field("error_total", seen_result.error_total, error_total);
                    check_field("frame_end", 16'(seen_result.frame_end), 16'(frame_end));
                end
            end
            // one long hold-off, otherwise random stalls
            if (burst_arm && !burst_taken)
            begin
                burst_taken <= 1'b1;
                burst_left  <= STALL_BURST;
                out_stall   <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left <= burst_left - 1;
                out_stall  <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic push_item(input logic [GCR_W-1:0] raw, input logic last);
        gcr_item_t it;
        it.raw  = raw;
        it.last = last;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Pack 5-bit codes MSB first into bytes, random pad on the tail
    task automatic push_codes(input int codes[$], input bit mark_last);
        logic [15:0]      shreg;
        int               nbits;
        logic [GCR_W-1:0] bytes[$];
        shreg = '0;
        nbits = 0;
        foreach (codes[i])
        begin
            shreg = (shreg << 5) | 16'(codes[i] & 'h1F);
            nbits += 5;
            if (nbits >= 8)
            begin
                bytes.push_back(GCR_W'(shreg >> (nbits - 8)));
                nbits -= 8;
            end
        end
        if (nbits > 0)
        begin
            shreg = (shreg << (8 - nbits)) | 16'($urandom_range(0, (1 << (8 - nbits)) - 1));
            bytes.push_back(GCR_W'(shreg));
        end
        foreach (bytes[i])
            push_item(bytes[i], mark_last && (i == bytes.size() - 1));
    endtask

    // Mostly well-formed frames, some with bad codes; the rest raw noise
    task automatic add_random_frames(input int n_items);
        int codes[$];
        int len;
        int target;
        target = items_queued + n_items;
        while (items_queued < target)
        begin
            codes.delete();
            if ($urandom_range(0, 9) < 7)
            begin
                len = $urandom_range(1, 24);
                repeat (len)
                    codes.push_back(($urandom_range(0, 11) == 0) ? $urandom_range(0, 31)
                                    : good_codes[$urandom_range(0, good_codes.size() - 1)]);
                push_codes(codes, 1'b1);
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                    push_item(GCR_W'($urandom_range(0, 255)),
                              (k == len - 1) && ($urandom_range(0, 3) != 0));
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_table_select(input table_sel_t sel);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_IDX_TABLE_SELECT));
        pwdata  <= APB_DATA_W'(sel);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        table_sel_q = sel;
        @(negedge clk);
    endtask

    // Sequence
    initial
    begin
        int codes[$];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n = 1'b0;
        for (int c = 0; c < 32; c++)
            if (GOOD_CODE_MASK[c])
                good_codes.push_back(c);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: byte extremes, one-byte frame, every code once
        send_idle_pct = 34;
        recv_idle_pct = 71;
        write_table_select(TSEL_STANDARD);
        push_item(8'hFF, 1'b1);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b1);
        for (int c = 0; c < 32; c++)
            codes.push_back(c);
        push_codes(codes, 1'b1);
        wait_drained();

        // random, sender idles less than receiver
        write_table_select(TSEL_SCRAMBLE_ONE);
        add_random_frames(170);
        wait_drained();

        // random, swapped idling, with a sender pause until drained
        send_idle_pct = 71;
        recv_idle_pct = 34;
        write_table_select(TSEL_SCRAMBLE_TWO);
        add_random_frames(170);
        while (pending_items.size() > 85)
            @(negedge clk);
        sender_hold = 1'b1;
        while (in_valid || expected_results.size() != 0)
            @(negedge clk);
        sender_hold = 1'b0;
        wait_drained();

        // random, no idling, one long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_table_select(TSEL_SCRAMBLE_THREE);
        add_random_frames(170);
        burst_arm = 1'b1;
        wait_drained();

        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
